FILE: src/wwcim_pkg.sv
// Shared types, constants and byte helpers for the whole-word case-insensitive matcher.
// No dependencies; used by wwcim_cell, wwcim_cfg and whole_word_case_insensitive_match.
package wwcim_pkg;

	localparam int BYTE_W      = 8;
	localparam int WORD_REG_W  = 64;
	localparam int WORD_BYTES  = 16;
	localparam int LEN_W       = 5;
	localparam int CFG_IDX_W   = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN  = 2'd2;

	localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [BYTE_W-1:0] CH_DIGIT_0 = 8'h30;
	localparam logic [BYTE_W-1:0] CH_DIGIT_9 = 8'h39;
	localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

	// Per-cell compare status handed to the top level
	typedef struct packed {
		logic eq_cur;
		logic eq_shift;
	} cell_stat_t;

	// Fold A..Z to a..z, leave every other byte alone
	function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r = c + CASE_DELTA;
		end
		return r;
	endfunction

	// ASCII letter or digit
	function automatic logic is_alnum_byte(input logic [BYTE_W-1:0] c);
		return (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
			(c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
			(c >= CH_UPPER_A && c <= CH_UPPER_Z);
	endfunction

endpackage

FILE: src/wwcim_cell.sv
// One history cell: holds one folded line byte and its letter/digit flag.
// Depends on wwcim_pkg.
module wwcim_cell (
	input  logic                            clk,
	input  logic                            shift_en,
	input  logic [wwcim_pkg::BYTE_W-1:0]    byte_in,
	input  logic                            alnum_in,
	input  logic [wwcim_pkg::BYTE_W-1:0]    target,
	output logic [wwcim_pkg::BYTE_W-1:0]    byte_out,
	output logic                            alnum_out,
	output wwcim_pkg::cell_stat_t           stat
);

	logic [wwcim_pkg::BYTE_W-1:0] byte_q;
	logic                         alnum_q;

	// Take the neighbor's byte on each shift
	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q  <= byte_in;
			alnum_q <= alnum_in;
		end
	end

	// Compare the held byte and the byte about to arrive
	assign stat.eq_cur   = (byte_q == target);
	assign stat.eq_shift = (byte_in == target);
	assign byte_out      = byte_q;
	assign alnum_out     = alnum_q;

endmodule

FILE: src/wwcim_cfg.sv
// Configuration registers and per-cell target bytes, reversed by word length and folded.
// Depends on wwcim_pkg.
module wwcim_cfg #(
	parameter int MAX_WORD = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     wr_en,
	input  logic [wwcim_pkg::CFG_IDX_W-1:0]          wr_index,
	input  logic [wwcim_pkg::WORD_REG_W-1:0]         wr_data,
	output logic [wwcim_pkg::LEN_W-1:0]              len_used,
	output logic [MAX_WORD-1:0]                      use_mask,
	output logic [MAX_WORD-1:0][wwcim_pkg::BYTE_W-1:0] target
);

	logic [wwcim_pkg::WORD_REG_W-1:0] word_low_q;
	logic [wwcim_pkg::WORD_REG_W-1:0] word_high_q;
	logic [wwcim_pkg::LEN_W-1:0]      length_q;
	logic [wwcim_pkg::WORD_BYTES-1:0][wwcim_pkg::BYTE_W-1:0] word_arr;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_low_q  <= '0;
			word_high_q <= '0;
			length_q    <= wwcim_pkg::LEN_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				wwcim_pkg::CFG_WORD_LOW:  word_low_q  <= wr_data;
				wwcim_pkg::CFG_WORD_HIGH: word_high_q <= wr_data;
				wwcim_pkg::CFG_WORD_LEN:  length_q    <= wr_data[wwcim_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp length to 1..MAX_WORD
	always_comb begin
		priority if (length_q == '0) begin
			len_used = wwcim_pkg::LEN_W'(1);
		end else if (length_q > wwcim_pkg::LEN_W'(MAX_WORD)) begin
			len_used = wwcim_pkg::LEN_W'(MAX_WORD);
		end else begin
			len_used = length_q;
		end
	end

	assign word_arr = {word_high_q, word_low_q};

	// Cell i holds the byte that must equal word byte len-1-i
	for (genvar i = 0; i < MAX_WORD; i++) begin : g_tgt
		logic [wwcim_pkg::LEN_W-1:0] idx;
		assign idx         = len_used - wwcim_pkg::LEN_W'(i + 1);
		assign use_mask[i] = wwcim_pkg::LEN_W'(i) < len_used;
		assign target[i]   = wwcim_pkg::fold_byte(word_arr[idx[3:0]]);
	end

endmodule

FILE: src/whole_word_case_insensitive_match.sv
// Top level of the whole-word case-insensitive matcher: a chain of history cells.
// Depends on wwcim_pkg, wwcim_cfg and wwcim_cell.
//
// Usage: bytes of a line enter on the input channel (in_valid/in_stall,
// char_in, line_end), one word per cycle while in_stall is low. The line's last word (line_end=1)
// yields one result word on the output channel (out_valid/out_stall, found):
// 1 if the configured word occurs in the line as a whole word, case folded.
// A zero byte ends the line early; bytes after it up to line_end are dropped.
// Each nonzero byte shifts into a row of MAX_WORD+1 cells; each cell compares its
// byte with its word byte, so all end positions are checked every cycle.
// Throughput: one byte per cycle while in_stall is low; the cell compare is combinational.
// found is registered and appears in the cycle after the last byte is accepted.
// The result sits in an output register; non-last bytes are taken while it
// waits. in_stall rises only when a result is held and stalled and the
// offered byte is itself a line end.
// Reset clears the line state, out_valid and the word (length 1).
// Write the configuration port (wr_en, wr_index, wr_data) only when idle.
module whole_word_case_insensitive_match #(
	parameter int MAX_WORD = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [wwcim_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [wwcim_pkg::WORD_REG_W-1:0]     wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [wwcim_pkg::BYTE_W-1:0]         char_in,
	input  logic                                 line_end,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 found
);

	localparam int NCELL  = MAX_WORD + 1;
	localparam int CNT_W  = $clog2(MAX_WORD + 2);
	localparam int IDX_W  = $clog2(MAX_WORD + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WORD + 1);

	logic [wwcim_pkg::LEN_W-1:0]                   len_used;
	logic [MAX_WORD-1:0]                           use_mask;
	logic [MAX_WORD-1:0][wwcim_pkg::BYTE_W-1:0]    target;
	logic [NCELL-1:0][wwcim_pkg::BYTE_W-1:0]       cell_byte;
	logic [NCELL-1:0]                              cell_alnum;
	wwcim_pkg::cell_stat_t                         cell_stat [NCELL];
	logic [NCELL-1:0]                              eq_cur;
	logic [NCELL-1:0]                              eq_shift;
	logic [NCELL-1:0]                              use_ext;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nx;
	logic             hit_q;
	logic             halted_q;
	logic             out_valid_q;
	logic             found_q;

	logic                        accept;
	logic                        is_zero;
	logic [wwcim_pkg::BYTE_W-1:0] lc;
	logic                        lc_alnum;
	logic                        shift_en;
	logic                        match_cur;
	logic                        match_shift;
	logic                        hit_step;
	logic                        hit_final;
	logic [wwcim_pkg::LEN_W-1:0] cnt_ext;
	logic [wwcim_pkg::LEN_W-1:0] cnt_nx_ext;
	logic [IDX_W-1:0]            len_idx;
	logic [IDX_W-1:0]            len_m1_idx;

	wwcim_cfg #(
		.MAX_WORD (MAX_WORD)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.len_used (len_used),
		.use_mask (use_mask),
		.target   (target)
	);

	// Input byte folding and handshake
	assign accept   = in_valid && !in_stall;
	assign in_stall = out_valid_q && out_stall && line_end;
	assign is_zero  = (char_in == '0);
	assign lc       = wwcim_pkg::fold_byte(char_in);
	assign lc_alnum = wwcim_pkg::is_alnum_byte(lc);
	assign shift_en = accept && !halted_q && !is_zero;

	// Row of history cells; cell 0 holds the newest byte
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic [wwcim_pkg::BYTE_W-1:0] b_in;
		logic                         a_in;
		logic [wwcim_pkg::BYTE_W-1:0] tgt;
		if (i == 0) begin : g_head
			assign b_in = lc;
			assign a_in = lc_alnum;
		end else begin : g_body
			assign b_in = cell_byte[i-1];
			assign a_in = cell_alnum[i-1];
		end
		if (i < MAX_WORD) begin : g_tg
			assign tgt = target[i];
		end else begin : g_tail
			assign tgt = '0;
		end
		wwcim_cell u_cell (
			.clk       (clk),
			.shift_en  (shift_en),
			.byte_in   (b_in),
			.alnum_in  (a_in),
			.target    (tgt),
			.byte_out  (cell_byte[i]),
			.alnum_out (cell_alnum[i]),
			.stat      (cell_stat[i])
		);
		assign eq_cur[i]   = cell_stat[i].eq_cur;
		assign eq_shift[i] = cell_stat[i].eq_shift;
	end

	// Window checks on the held row and on the row after this shift
	assign use_ext    = {1'b0, use_mask};
	assign count_nx   = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);
	assign cnt_ext    = wwcim_pkg::LEN_W'(count_q);
	assign cnt_nx_ext = wwcim_pkg::LEN_W'(count_nx);
	assign len_idx    = IDX_W'(len_used);
	assign len_m1_idx = IDX_W'(len_used - wwcim_pkg::LEN_W'(1));

	assign match_cur = (cnt_ext >= len_used) && (&(eq_cur | ~use_ext)) &&
		!((cnt_ext > len_used) && cell_alnum[len_idx]);
	assign match_shift = (cnt_nx_ext >= len_used) && (&(eq_shift | ~use_ext)) &&
		!((cnt_nx_ext > len_used) && cell_alnum[len_m1_idx]);

	// A byte that is neither letter nor digit, or a zero byte, closes the window held in the row
	assign hit_step  = !halted_q && match_cur && (is_zero || !lc_alnum);
	assign hit_final = hit_q || hit_step || (!halted_q && !is_zero && match_shift);

	// Line state: advance on each shifted byte, clear after the line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			hit_q    <= 1'b0;
			halted_q <= 1'b0;
		end else if (accept) begin
			if (line_end) begin
				count_q  <= '0;
				hit_q    <= 1'b0;
				halted_q <= 1'b0;
			end else begin
				hit_q    <= hit_q || hit_step;
				halted_q <= halted_q || is_zero;
				if (shift_en) begin
					count_q <= count_nx;
				end
			end
		end
	end

	// Output register: load on the line end, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && line_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && line_end) begin
			found_q <= hit_final;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;

	// A line end always leaves a result waiting
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && line_end |=> out_valid)
		else $error("line end did not produce a result");

	// A line end clears the line state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && line_end |=> (count_q == '0) && !hit_q && !halted_q)
		else $error("line state not cleared after line end");

	// Bytes after a zero byte leave the row untouched
	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && halted_q && !line_end |=> $stable(count_q) && halted_q)
		else $error("row advanced after line halted");

	// Input is held back only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && out_stall)
		else $error("input stalled with no waiting result");

endmodule

FILE: tb/sv/wwcim_match_checker.sv
`timescale 1ns / 1ps
// Checker for the whole-word case-insensitive matcher: follows register writes, scans
// every accepted byte word and compares each found word against the predicted verdict.
// Depends on wwcim_pkg for widths and register indexes.
module wwcim_match_checker #(
	parameter int MAX_WORD = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [wwcim_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [wwcim_pkg::WORD_REG_W-1:0]     wr_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [wwcim_pkg::BYTE_W-1:0]         char_in,
	input  logic                                 line_end,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic                                 found,
	output int                                   errors,
	output int                                   outstanding
);

	localparam int DEPTH = MAX_WORD + 1;

	// word registers as last written
	logic [wwcim_pkg::WORD_REG_W-1:0] key_lo;
	logic [wwcim_pkg::WORD_REG_W-1:0] key_hi;
	logic [wwcim_pkg::LEN_W-1:0]      key_len;

	// line state: lower-cased bytes, newest at index 0
	logic [wwcim_pkg::BYTE_W-1:0] recent [DEPTH];
	int                seen;
	bit                hit;
	bit                stopped;

	// verdicts of finished lines not yet seen on the output
	bit verdicts [$];
	bit due;

	function automatic logic [wwcim_pkg::BYTE_W-1:0] to_lower(
		input logic [wwcim_pkg::BYTE_W-1:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c | 8'h20;
		end
		return c;
	endfunction

	function automatic bit word_char(input logic [wwcim_pkg::BYTE_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h41 && c <= 8'h5A);
	endfunction

	// clamp the length register to 1..MAX_WORD
	function automatic int span();
		int n;
		n = key_len;
		if (n == 0) n = 1;
		if (n > MAX_WORD) n = MAX_WORD;
		return n;
	endfunction

	function automatic logic [wwcim_pkg::BYTE_W-1:0] key_byte(input int i);
		return (i < 8) ? key_lo[i*8 +: 8] : key_hi[(i-8)*8 +: 8];
	endfunction

	// word ends at the newest byte with a clean left neighbor
	function automatic bit ends_word();
		int n;
		n = span();
		if (seen < n) return 0;
		for (int i = 0; i < n; i++) begin
			if (recent[n-1-i] != to_lower(key_byte(i))) return 0;
		end
		if (seen > n && word_char(recent[n])) return 0;
		return 1;
	endfunction

	task automatic clear_line();
		for (int i = 0; i < DEPTH; i++) recent[i] = '0;
		seen = 0;
		hit = 0;
		stopped = 0;
	endtask

	// advance the line by one byte; queue the verdict on the last one
	task automatic scan_byte(input logic [wwcim_pkg::BYTE_W-1:0] c, input logic last);
		logic [wwcim_pkg::BYTE_W-1:0] lc;
		lc = to_lower(c);
		if (!stopped) begin
			if (c == 8'h00) begin
				if (ends_word()) hit = 1;
				stopped = 1;
			end else begin
				if (!word_char(lc) && ends_word()) hit = 1;
				for (int i = DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
				recent[0] = lc;
				if (seen < DEPTH) seen++;
			end
		end
		if (last) begin
			if (!stopped && ends_word()) hit = 1;
			verdicts = {verdicts, hit};
			clear_line();
		end
	endtask

	// compare results first: a result never belongs to a byte taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo = '0;
			key_hi = '0;
			key_len = wwcim_pkg::LEN_W'(1);
			clear_line();
			verdicts.delete();
			outstanding = 0;
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdicts.size() == 0) begin
					$error("found: expected no word, actual %0d", found);
					errors++;
				end else begin
					due = verdicts.pop_front();
					if (found !== due) begin
						$error("found: expected %0d, actual %0d", due, found);
						errors++;
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					wwcim_pkg::CFG_WORD_LOW:  key_lo = wr_data;
					wwcim_pkg::CFG_WORD_HIGH: key_hi = wr_data;
					wwcim_pkg::CFG_WORD_LEN:  key_len = wr_data[wwcim_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) scan_byte(char_in, line_end);
			outstanding = verdicts.size();
		end
	end

endmodule

FILE: tb/sv/tb_whole_word_case_insensitive_match.sv
`timescale 1ns / 1ps
// Testbench top for whole_word_case_insensitive_match: clock, reset, line stimulus,
// receiver stalls and the verdict. Depends on wwcim_pkg, the block and wwcim_match_checker.
module tb_whole_word_case_insensitive_match;

	localparam int MAX_WORD    = 16;
	localparam int LONG_HOLD   = 80;
	localparam int PHASES      = 8;
	localparam int PHASE_BYTES = 54;

	logic                             clk;
	logic                             arst_n;
	logic                             wr_en;
	logic [wwcim_pkg::CFG_IDX_W-1:0]  wr_index;
	logic [wwcim_pkg::WORD_REG_W-1:0] wr_data;
	logic                             in_valid;
	logic                             in_stall;
	logic [wwcim_pkg::BYTE_W-1:0]     char_in;
	logic                             line_end;
	logic                             out_valid;
	logic                             out_stall;
	logic                             found;
	int                               errors;
	int                               outstanding;

	// idle and stall rates in percent, set per phase
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_kick = 0;

	// word as programmed, and the line being built
	logic [wwcim_pkg::BYTE_W-1:0] key [MAX_WORD];
	int                           key_span = 1;
	logic [wwcim_pkg::BYTE_W-1:0] line_buf [$];
	int                           phase_bytes = 0;

	whole_word_case_insensitive_match #(.MAX_WORD(MAX_WORD)) dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .char_in(char_in), .line_end(line_end),
		.out_valid(out_valid), .out_stall(out_stall), .found(found)
	);

	wwcim_match_checker #(.MAX_WORD(MAX_WORD)) match_check (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .char_in(char_in), .line_end(line_end),
		.out_valid(out_valid), .out_stall(out_stall), .found(found),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_whole_word_case_insensitive_match: FAIL");
		$finish;
	end

	// receiver: random stalls, or a long hold when kicked
	initial begin : receiver
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_kick != hold_seen) begin
				hold_seen = hold_kick;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1;
			end else begin
				out_stall = ($urandom_range(0, 99) < recv_stall);
			end
		end
	end

	function automatic logic [wwcim_pkg::BYTE_W-1:0] rand_letter();
		logic [wwcim_pkg::BYTE_W-1:0] c;
		c = 8'h61 + 8'($urandom_range(0, 25));
		return $urandom_range(0, 1) ? c : (c & 8'hDF);
	endfunction

	// bytes that are neither letters nor digits, many right at the class edges
	function automatic logic [wwcim_pkg::BYTE_W-1:0] separator();
		case ($urandom_range(0, 8))
			0: return 8'h20;
			1: return 8'h2F;
			2: return 8'h3A;
			3: return 8'h40;
			4: return 8'h5B;
			5: return 8'h60;
			6: return 8'h7B;
			7: return 8'($urandom_range(128, 255));
			default: return 8'($urandom_range(1, 31));
		endcase
	endfunction

	function automatic logic [wwcim_pkg::BYTE_W-1:0] filler();
		case ($urandom_range(0, 3))
			0, 1: return rand_letter();
			2: return 8'h30 + 8'($urandom_range(0, 9));
			default: return separator();
		endcase
	endfunction

	function automatic int span_of(input int len_reg);
		if (len_reg < 1) return 1;
		if (len_reg > MAX_WORD) return MAX_WORD;
		return len_reg;
	endfunction

	function automatic int plan_length(input int p);
		case (p)
			0: return 16;
			1: return 31;
			2: return 1;
			3: return 17;
			5: return 0;
			7: return 16;
			default: return $urandom_range(2, 15);
		endcase
	endfunction

	// append one byte to the line being built
	task automatic add_byte(input logic [wwcim_pkg::BYTE_W-1:0] c);
		line_buf = {line_buf, c};
	endtask

	// fill the word with mostly letters; optionally plant a zero byte
	task automatic random_key(input int zero_at);
		for (int i = 0; i < MAX_WORD; i++) begin
			case ($urandom_range(0, 9))
				0: key[i] = 8'h30 + 8'($urandom_range(0, 9));
				1: key[i] = 8'($urandom_range(1, 255));
				default: key[i] = rand_letter();
			endcase
		end
		if (zero_at >= 0) key[zero_at] = 8'h00;
	endtask

	// hold until every verdict is out and the block is quiet
	task automatic settle();
		in_valid = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic program_key(input int len_reg);
		logic [wwcim_pkg::WORD_REG_W-1:0] lo;
		logic [wwcim_pkg::WORD_REG_W-1:0] hi;
		for (int i = 0; i < 8; i++) begin
			lo[i*8 +: 8] = key[i];
			hi[i*8 +: 8] = key[i+8];
		end
		settle();
		wr_en = 1;
		wr_index = wwcim_pkg::CFG_WORD_LOW;
		wr_data = lo;
		@(negedge clk);
		wr_index = wwcim_pkg::CFG_WORD_HIGH;
		wr_data = hi;
		@(negedge clk);
		// upper bits of the length write carry noise
		wr_index = wwcim_pkg::CFG_WORD_LEN;
		wr_data = {32'($urandom), 27'($urandom), 5'(len_reg)};
		@(negedge clk);
		wr_en = 0;
		key_span = span_of(len_reg);
	endtask

	// offer one byte word and wait for it to be taken
	task automatic send_byte(input logic [wwcim_pkg::BYTE_W-1:0] c, input logic last);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		char_in = c;
		line_end = last;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		phase_bytes++;
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++) begin
			send_byte(line_buf[i], i == line_buf.size() - 1);
		end
		line_buf.delete();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	// copy the first n word bytes, flipping the case of letters at random
	task automatic push_key(input int n);
		logic [wwcim_pkg::BYTE_W-1:0] c;
		for (int i = 0; i < n; i++) begin
			c = key[i];
			if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
				c = $urandom_range(0, 1) ? (c | 8'h20) : (c & 8'hDF);
			end
			add_byte(c);
		end
	endtask

	task automatic make_line();
		case ($urandom_range(0, 9))
			// word among filler, usually fenced by separators
			0, 1, 2, 3, 4, 5: begin
				repeat ($urandom_range(0, 3)) add_byte(filler());
				if ($urandom_range(0, 2) != 0) add_byte(separator());
				push_key(key_span);
				if ($urandom_range(0, 2) != 0) add_byte(separator());
				repeat ($urandom_range(0, 3)) add_byte(filler());
			end
			// partial copy just ahead of the full word: overlapping candidates
			6: begin
				push_key($urandom_range(1, key_span));
				if ($urandom_range(0, 1)) add_byte(separator());
				push_key(key_span);
				if ($urandom_range(0, 1)) add_byte(separator());
			end
			7: repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
			// zero byte cuts the line, trailing bytes are dropped
			8: begin
				push_key(key_span);
				add_byte(8'h00);
				repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
			end
			// letter or digit glued to the word
			default: begin
				if ($urandom_range(0, 1)) add_byte(rand_letter());
				push_key(key_span);
				if ($urandom_range(0, 1)) add_byte(8'h30 + 8'($urandom_range(0, 9)));
			end
		endcase
	endtask

	initial begin : stimulus
		int len_reg;
		arst_n = 0;
		wr_en = 0;
		wr_index = wwcim_pkg::CFG_WORD_LOW;
		wr_data = '0;
		in_valid = 0;
		char_in = '0;
		line_end = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// word after reset is a lone zero byte: nothing matches
		push_text("a");
		send_line();

		// three-byte word with a capital in the register
		random_key(-1);
		key[0] = "c";
		key[1] = "A";
		key[2] = "t";
		program_key(3);
		push_text("CAT");
		send_line();
		push_text("@cat[");
		send_line();
		add_byte(8'hFF);
		push_text("cat");
		send_line();
		// empty line
		add_byte(8'h00);
		send_line();
		// zero byte on the line end
		push_text("cat");
		add_byte(8'h00);
		send_line();
		push_text("ca");
		add_byte(8'h00);
		push_text("t");
		send_line();

		// zero length acts as one
		key[0] = "C";
		program_key(0);
		push_text("c");
		send_line();

		// random lines over several word settings and idle patterns
		for (int p = 0; p < PHASES; p++) begin
			len_reg = plan_length(p);
			random_key((p == 6) ? $urandom_range(0, span_of(len_reg) - 1) : -1);
			program_key(len_reg);
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 63; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 63; end
				default: begin send_idle = 14; recv_stall = 14; end
			endcase
			phase_bytes = 0;
			// long receiver hold while short lines keep coming: input must back up
			if (p == 2) begin
				@(posedge clk);
				hold_kick = ~hold_kick;
				@(negedge clk);
				repeat (12) begin
					if ($urandom_range(0, 1)) add_byte(filler());
					push_key(key_span);
					send_line();
				end
			end
			while (phase_bytes < PHASE_BYTES) begin
				make_line();
				send_line();
			end
		end

		settle();
		repeat (2) @(negedge clk);
		if (errors == 0) begin
			$display("tb_whole_word_case_insensitive_match: PASS");
		end else begin
			$display("tb_whole_word_case_insensitive_match: FAIL");
		end
		$finish;
	end

endmodule
